/* sv/signed_int_to_radix_text_macros.svh */
// Assertion macros used by the checker module.
`ifndef SIGNED_INT_TO_RADIX_TEXT_MACROS_SVH
`define SIGNED_INT_TO_RADIX_TEXT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define SIRT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sirt assertion failed");

// Next-cycle implication, off while reset is high.
`define SIRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sirt assertion failed");

// Next-cycle implication that also covers reset itself.
`define SIRT_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sirt assertion failed");

`endif

/* sv/sirt_pkg.sv */
// Types, constants and helpers shared by the radix text converter.
package sirt_pkg;

  localparam int MAG_W      = 32;
  localparam int MAX_BASE   = 16;
  localparam int MAX_DIGITS = 32;
  localparam int DIGIT_W    = $clog2(MAX_BASE);
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int BASE_W     = 5;
  localparam int CHAR_W     = 8;
  localparam int ALPHA_W    = MAX_BASE * CHAR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_LOW   = 8'd33;
  localparam logic [CHAR_W-1:0] CHAR_HIGH  = 8'd126;

  localparam logic [IDX_W-1:0] STEP_LAST = IDX_W'(MAG_W - 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_HIGH = 2'd2;

  // Request handed from the front end to the back end.
  typedef struct packed {
    logic             bad;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } cmd_t;

  // Queue status: full gates pushes, empty tells the back end a request waits.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // One result request.
  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last;
    logic              bad;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ERR,
    BK_CONV,
    BK_SIGN,
    BK_EMIT
  } back_state_t;

  // Character k of the packed alphabet.
  function automatic logic [CHAR_W-1:0] alpha_char(input logic [ALPHA_W-1:0] alphabet,
                                                   input logic [DIGIT_W-1:0] k);
    return alphabet[{k, 3'b000} +: CHAR_W];
  endfunction

endpackage

/* sv/sirt_fifo.sv */
// Two-entry request queue between the front end and the back end.
module sirt_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  sirt_pkg::cmd_t    wr_data,
  input  logic              rd_en,
  output sirt_pkg::cmd_t    rd_data,
  output sirt_pkg::q_status_t status
);
  import sirt_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign rd_data      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/sirt_front.sv */
// Front end: alphabet check and sign/magnitude split of each request.
module sirt_front (
  input  logic signed [31:0]                   value,
  input  logic [sirt_pkg::BASE_W-1:0]          base_size,
  input  logic [sirt_pkg::ALPHA_W-1:0]         alphabet,
  output sirt_pkg::cmd_t                       cmd
);
  import sirt_pkg::*;

  logic [CHAR_W-1:0]   ch [MAX_BASE];
  logic [MAX_BASE-1:0] used;
  logic                bad_size;
  logic                bad_char;
  logic                dup;

  always_comb begin
    bad_char = 1'b0;
    dup      = 1'b0;
    bad_size = (base_size < BASE_W'(2)) || (base_size > BASE_W'(MAX_BASE));
    for (int a = 0; a < MAX_BASE; a++) begin
      ch[a]   = alpha_char(alphabet, DIGIT_W'(a));
      used[a] = (BASE_W'(a) < base_size);
    end
    for (int a = 0; a < MAX_BASE; a++) begin
      if (used[a] && ((ch[a] < CHAR_LOW) || (ch[a] > CHAR_HIGH) ||
                      (ch[a] == CHAR_PLUS) || (ch[a] == CHAR_MINUS))) begin
        bad_char = 1'b1;
      end
      for (int b = a + 1; b < MAX_BASE; b++) begin
        if (used[b] && (ch[a] == ch[b])) begin
          dup = 1'b1;
        end
      end
    end
  end

  always_comb begin
    cmd.bad = bad_size || bad_char || dup;
    cmd.neg = value[MAG_W-1];
    cmd.mag = value[MAG_W-1] ? (MAG_W'(0) - unsigned'(value)) : unsigned'(value);
  end

endmodule

/* sv/sirt_back.sv */
// Back end: bit-serial radix conversion and character emission.
module sirt_back (
  input  logic                          clk,
  input  logic                          rst,
  input  sirt_pkg::cmd_t                cmd,
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  input  logic [sirt_pkg::BASE_W-1:0]   base_size,
  input  logic [sirt_pkg::ALPHA_W-1:0]  alphabet,
  output sirt_pkg::res_t                res,
  output logic                          res_valid,
  input  logic                          res_pop
);
  import sirt_pkg::*;

  back_state_t        state;
  back_state_t        state_next;
  logic [MAG_W-1:0]   mag;
  logic               neg;
  logic [IDX_W-1:0]   step;
  logic [DIGIT_W-1:0] digits [MAX_DIGITS];
  logic [CNT_W-1:0]   ndig;
  logic [IDX_W-1:0]   idx;

  logic [BASE_W-1:0]     twice      [MAX_DIGITS];
  logic [DIGIT_W-1:0]    digit_next [MAX_DIGITS];
  logic [MAX_DIGITS-1:0] gen;
  logic [MAX_DIGITS-1:0] prop;
  logic [MAX_DIGITS:0]   sum;
  logic [MAX_DIGITS:0]   carry;
  logic [CNT_W-1:0]      ndig_step;

  logic slot_free;
  logic start;
  logic conv_en;
  logic idx_dec;
  logic res_load;
  res_t res_next;

  assign slot_free = !res_valid || res_pop;

  // Digit vector times two plus the next magnitude bit, carries via one add.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      twice[i] = {digits[i], 1'b0};
      gen[i]   = (twice[i] >= base_size);
      prop[i]  = (twice[i] == (base_size - BASE_W'(1)));
    end
    sum   = {1'b0, gen | prop} + {1'b0, gen} + {{MAX_DIGITS{1'b0}}, mag[MAG_W-1]};
    carry = {sum[MAX_DIGITS], sum[MAX_DIGITS-1:0] ^ prop};
    for (int i = 0; i < MAX_DIGITS; i++) begin
      digit_next[i] = DIGIT_W'(twice[i] + BASE_W'(carry[i])
                               - (carry[i+1] ? base_size : BASE_W'(0)));
    end
    ndig_step = carry[ndig] ? (ndig + CNT_W'(1)) : ndig;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    start      = 1'b0;
    conv_en    = 1'b0;
    idx_dec    = 1'b0;
    res_load   = 1'b0;
    res_next   = '0;
    case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          start      = 1'b1;
          state_next = cmd.bad ? BK_ERR : BK_CONV;
        end
      end
      BK_ERR: begin
        if (slot_free) begin
          res_load   = 1'b1;
          res_next   = '{out_char: '0, last: 1'b1, bad: 1'b1};
          state_next = BK_IDLE;
        end
      end
      BK_CONV: begin
        conv_en = 1'b1;
        if (step == STEP_LAST) begin
          state_next = neg ? BK_SIGN : BK_EMIT;
        end
      end
      BK_SIGN: begin
        if (slot_free) begin
          res_load   = 1'b1;
          res_next   = '{out_char: CHAR_MINUS, last: 1'b0, bad: 1'b0};
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          res_load = 1'b1;
          res_next = '{out_char: alpha_char(alphabet, digits[idx]),
                       last: (idx == '0), bad: 1'b0};
          if (idx == '0) begin
            state_next = BK_IDLE;
          end else begin
            idx_dec = 1'b1;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag  <= cmd.mag;
      neg  <= cmd.neg;
      step <= '0;
      ndig <= '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digits[i] <= '0;
      end
    end else if (conv_en) begin
      mag  <= {mag[MAG_W-2:0], 1'b0};
      step <= step + IDX_W'(1);
      ndig <= ndig_step;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digits[i] <= digit_next[i];
      end
    end
    // Point at the top digit; zero still has one digit.
    if (conv_en && (step == STEP_LAST)) begin
      idx <= (ndig_step == '0) ? '0 : IDX_W'(ndig_step - CNT_W'(1));
    end else if (idx_dec) begin
      idx <= idx - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_pop) begin
      res_valid <= 1'b0;
    end
  end

endmodule

/* sv/signed_int_to_radix_text.sv */
// Top level of the signed integer to radix text converter.
// Each pushed value is written as text in the configured radix, one character per
// popped request, most significant first, with a leading '-' for negatives and
// last set on the final character; a bad alphabet gives a single request with
// bad_alphabet and last set and out_char zero. The back end's bit-serial converter
// takes one magnitude bit per cycle, whatever the value's size, and then sends the
// characters through the single output register; a two-entry queue lets the next
// values be pushed meanwhile.
module signed_int_to_radix_text (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [31:0]                  value,
  output logic                                empty,
  input  logic                                pop,
  output logic [7:0]                          out_char,
  output logic                                last,
  output logic                                bad_alphabet,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sirt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sirt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sirt_pkg::*;

  logic [BASE_W-1:0]     base_size;
  logic [CFG_DATA_W-1:0] alphabet_low;
  logic [CFG_DATA_W-1:0] alphabet_high;
  logic [ALPHA_W-1:0]    alphabet;

  cmd_t      front_cmd;
  cmd_t      q_cmd;
  q_status_t q_status;
  logic      q_pop;
  res_t      res;
  logic      res_valid;

  assign cfg_ready = 1'b1;
  assign alphabet  = {alphabet_high, alphabet_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      base_size     <= '0;
      alphabet_low  <= '0;
      alphabet_high <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BASE_SIZE:     base_size     <= cfg_data[BASE_W-1:0];
        REG_ALPHABET_LOW:  alphabet_low  <= cfg_data;
        REG_ALPHABET_HIGH: alphabet_high <= cfg_data;
        default: ;
      endcase
    end
  end

  sirt_front u_front (
    .value     (value),
    .base_size (base_size),
    .alphabet  (alphabet),
    .cmd       (front_cmd)
  );

  sirt_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !q_status.full),
    .wr_data (front_cmd),
    .rd_en   (q_pop),
    .rd_data (q_cmd),
    .status  (q_status)
  );

  sirt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (q_cmd),
    .cmd_valid (!q_status.empty),
    .cmd_pop   (q_pop),
    .base_size (base_size),
    .alphabet  (alphabet),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (pop && res_valid)
  );

  assign full         = q_status.full;
  assign empty        = !res_valid;
  assign out_char     = res.out_char;
  assign last         = res.last;
  assign bad_alphabet = res.bad;

endmodule

/* sv/sirt_checker.sv */
// Port-level checks for the radix text converter, bound to the top level.
`include "signed_int_to_radix_text_macros.svh"

module sirt_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_char,
  input logic       last,
  input logic       bad_alphabet
);

  logic [9:0] res_bits;

  assign res_bits = {out_char, last, bad_alphabet};

  // Hold a waiting request until it is taken.
  `SIRT_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(res_bits))
  // An error request stands alone and carries no character.
  `SIRT_ASSERT_NOW(a_err_shape, !empty && bad_alphabet, last && (out_char == 8'd0))
  // Characters of one conversion follow without a gap.
  `SIRT_ASSERT_NEXT(a_no_gap, pop && !empty && !last, !empty)
  // Reset drops everything queued on both sides.
  `SIRT_ASSERT_RST(a_reset_clear, rst, empty && !full)

endmodule

bind signed_int_to_radix_text sirt_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .out_char     (out_char),
  .last         (last),
  .bad_alphabet (bad_alphabet)
);

/* tb/signed_int_to_radix_text_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the signed integer to radix text converter.
module signed_int_to_radix_text_tb;
  import sirt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 400;

  typedef enum int {POP_ALWAYS, POP_MOSTLY, POP_RARELY} pop_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  logic signed [31:0]    value = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [7:0]            out_char;
  logic                  last;
  logic                  bad_alphabet;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Local copy of the configuration registers.
  logic [BASE_W-1:0]     base_cfg = '0;
  logic [ALPHA_W-1:0]    alphabet_cfg = '0;

  logic signed [31:0]    pending_values[$];
  res_t                  expected_chars[$];
  int                    mismatch_count = 0;
  int                    hold_asks = 0;
  int                    holds_done = 0;
  int                    hold_left = 0;
  int                    burst_left = 0;
  int                    gap_left = 0;
  int                    mode_left = 0;
  pop_mode_t             pop_mode = POP_ALWAYS;
  int                    cycle_count = 0;

  signed_int_to_radix_text i_dut (.*);

  always #1 clk = ~clk;

  function automatic logic [CHAR_W-1:0] digit_char(int k);
    return alphabet_cfg[k*CHAR_W +: CHAR_W];
  endfunction

  function automatic bit alphabet_valid();
    logic [CHAR_W-1:0] c;
    if (base_cfg < 2 || base_cfg > MAX_BASE) return 1'b0;
    for (int a = 0; a < base_cfg; a++) begin
      c = digit_char(a);
      if (c < CHAR_LOW || c > CHAR_HIGH || c == CHAR_PLUS || c == CHAR_MINUS) return 1'b0;
      for (int b = a + 1; b < base_cfg; b++)
        if (digit_char(b) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Queue the characters that one value turns into.
  function automatic void predict_text(logic [31:0] raw);
    logic [31:0]        mag;
    logic [DIGIT_W-1:0] digits[MAX_DIGITS];
    int                 n;
    if (!alphabet_valid()) begin
      expected_chars.push_back('{out_char: '0, last: 1'b1, bad: 1'b1});
      return;
    end
    // Most negative value wraps to 2^31 here, as intended.
    mag = raw[31] ? 32'd0 - raw : raw;
    n = 0;
    if (mag == 0) begin
      digits[0] = '0;
      n = 1;
    end
    while (mag != 0) begin
      digits[n] = DIGIT_W'(mag % base_cfg);
      mag = mag / base_cfg;
      n++;
    end
    if (raw[31]) expected_chars.push_back('{out_char: CHAR_MINUS, last: 1'b0, bad: 1'b0});
    for (int k = n - 1; k >= 0; k--)
      expected_chars.push_back('{out_char: digit_char(digits[k]), last: k == 0, bad: 1'b0});
  endfunction

  function automatic logic [ALPHA_W-1:0] pack_text(string s);
    logic [ALPHA_W-1:0] a;
    a = '0;
    for (int k = 0; k < s.len(); k++) a[k*CHAR_W +: CHAR_W] = s[k];
    return a;
  endfunction

  function automatic logic signed [31:0] random_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: case ($urandom_range(0, 3))
        0: v = 32'sd0;
        1: v = -32'sd1;
        2: v = 32'sh8000_0000;
        default: v = 32'sh7FFF_FFFF;
      endcase
      1, 2: v = $signed($urandom_range(0, 600)) - 300;
      3: begin
        v = 32'sd1 <<< $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Mostly valid alphabets; about one in five is broken in some way.
  function automatic void make_random_config(output logic [BASE_W-1:0] base,
                                             output logic [ALPHA_W-1:0] alpha);
    logic [255:0]      used;
    logic [CHAR_W-1:0] c;
    int                spot;
    used = '0;
    for (int k = 0; k < MAX_BASE; k++) alpha[k*CHAR_W +: CHAR_W] = CHAR_W'($urandom);
    case ($urandom_range(0, 3))
      0: base = BASE_W'(2);
      1: base = BASE_W'(MAX_BASE);
      default: base = BASE_W'($urandom_range(3, MAX_BASE - 1));
    endcase
    for (int k = 0; k < base; k++) begin
      do c = CHAR_W'($urandom_range(CHAR_LOW, CHAR_HIGH));
      while (c == CHAR_PLUS || c == CHAR_MINUS || used[c]);
      used[c] = 1'b1;
      alpha[k*CHAR_W +: CHAR_W] = c;
    end
    if ($urandom_range(0, 4) == 0) begin
      spot = $urandom_range(0, base - 1);
      case ($urandom_range(0, 3))
        0: base = ($urandom_range(0, 1) == 1) ? BASE_W'($urandom_range(0, 1))
                                               : BASE_W'($urandom_range(MAX_BASE + 1, 31));
        1: alpha[spot*CHAR_W +: CHAR_W] = alpha[((spot + 1) % base)*CHAR_W +: CHAR_W];
        2: alpha[spot*CHAR_W +: CHAR_W] = ($urandom_range(0, 1) == 1) ? CHAR_PLUS : CHAR_MINUS;
        default: alpha[spot*CHAR_W +: CHAR_W] =
          ($urandom_range(0, 1) == 1) ? CHAR_W'($urandom_range(0, CHAR_LOW - 1))
                                      : CHAR_W'($urandom_range(CHAR_HIGH + 1, 255));
      endcase
    end
  endfunction

  // Leaves valid high so that a following write goes out without a gap.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BASE_SIZE:     base_cfg = data[BASE_W-1:0];
      REG_ALPHABET_LOW:  alphabet_cfg[CFG_DATA_W-1:0] = data;
      REG_ALPHABET_HIGH: alphabet_cfg[ALPHA_W-1:CFG_DATA_W] = data;
      default: ;
    endcase
  endtask

  task automatic load_config(logic [BASE_W-1:0] base, logic [ALPHA_W-1:0] alpha);
    logic [CFG_DATA_W-1:0] word;
    word = {$urandom, $urandom};
    word[BASE_W-1:0] = base;
    write_reg(REG_BASE_SIZE, word);
    write_reg(REG_ALPHABET_LOW, alpha[CFG_DATA_W-1:0]);
    write_reg(REG_ALPHABET_HIGH, alpha[ALPHA_W-1:CFG_DATA_W]);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_values.size() != 0 || push || expected_chars.size() != 0);
    @(posedge clk);
  endtask

  // Sender: bursts of requests separated by random gaps.
  always @(posedge clk) begin : drive
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_text(pending_values.pop_front());
        if (burst_left > 0) burst_left--;
      end
      // Hold a request that is not yet taken.
      if (!(push && full)) begin
        if (burst_left == 0 && gap_left == 0) begin
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
          burst_left = $urandom_range(1, 24);
        end
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (pending_values.size() != 0) begin
          push  <= 1'b1;
          value <= pending_values[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: pop pattern switches between modes, plus long holds on request.
  always @(posedge clk) begin : drain
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (holds_done != hold_asks) begin
        holds_done = hold_asks;
        hold_left  = LONG_HOLD;
      end
      if (mode_left == 0) begin
        pop_mode  = pop_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (pop_mode)
          POP_ALWAYS: pop <= 1'b1;
          POP_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
          default:    pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check
    res_t want;
    res_t got;
    if (!rst && pop && !empty) begin
      got = '{out_char: out_char, last: last, bad: bad_alphabet};
      if (expected_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected request: char %h last %b bad %b",
                   got.out_char, got.last, got.bad);
      end else begin
        want = expected_chars.pop_front();
        if (got.out_char != want.out_char || got.last != want.last || got.bad != want.bad) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: char %h/%h last %b/%b bad %b/%b (expected/actual)",
                     want.out_char, got.out_char, want.last, got.last, want.bad, got.bad);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [BASE_W-1:0]  base;
    logic [ALPHA_W-1:0] alpha;
    int                 random_sent;
    int                 phase;
    int                 n;
    random_sent = 0;
    phase = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset alphabet is empty: error request.
    @(negedge clk);
    pending_values.push_back(32'sd5);
    wait_drained();

    // Write to an unused index; the load below then sets every register.
    write_reg(REG_UNUSED, {$urandom, $urandom});
    load_config(BASE_W'(10), pack_text("0123456789"));
    @(negedge clk);
    pending_values.push_back(32'sd0);          pending_values.push_back(32'sd1);
    pending_values.push_back(-32'sd1);         pending_values.push_back(32'sh7FFF_FFFF);
    pending_values.push_back(32'sh8000_0000);  pending_values.push_back(32'sd10);
    pending_values.push_back(-32'sd10);        pending_values.push_back(32'sd123456789);
    wait_drained();

    // Binary: most negative value gives the longest text.
    load_config(BASE_W'(2), pack_text("01"));
    @(negedge clk);
    pending_values.push_back(32'sh8000_0000);  pending_values.push_back(32'sh7FFF_FFFF);
    pending_values.push_back(-32'sd1);         pending_values.push_back(32'sd0);
    wait_drained();

    load_config(BASE_W'(MAX_BASE), pack_text("0123456789ABCDEF"));
    @(negedge clk);
    pending_values.push_back(32'sh8000_0000);  pending_values.push_back(32'sh7FFF_FFFF);
    pending_values.push_back(32'sd0);          pending_values.push_back(-32'sd1);
    pending_values.push_back(32'sh1234_5678);
    wait_drained();

    // Broken alphabets: too large, repeated character, too small, plus sign.
    load_config(BASE_W'(MAX_BASE + 1), pack_text("0123456789ABCDEFG"));
    @(negedge clk);
    pending_values.push_back(32'sd42);
    wait_drained();
    load_config(BASE_W'(10), pack_text("0123406789"));
    @(negedge clk);
    pending_values.push_back(-32'sd42);
    wait_drained();
    load_config(BASE_W'(1), pack_text("0"));
    @(negedge clk);
    pending_values.push_back(32'sd7);
    wait_drained();
    load_config(BASE_W'(10), pack_text("0123+56789"));
    @(negedge clk);
    pending_values.push_back(32'sd99);
    wait_drained();

    while (random_sent < RANDOM_ITEMS) begin
      phase++;
      make_random_config(base, alpha);
      load_config(base, alpha);
      @(negedge clk);
      n = $urandom_range(15, 50);
      if (phase == 2 || phase == 7) begin
        hold_asks <= hold_asks + 1;
        n = 40;
      end
      repeat (n) pending_values.push_back(random_value());
      random_sent += n;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
